### hw/rtl/fenwick_pkg.sv
// ----------------------------------------------------------------------------
// Fenwick tree package
// Shared widths, command encoding and back-end state type.
// ----------------------------------------------------------------------------
package fenwick_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // add:   idx_a = position, idx_b unused
  // query: idx_a = clamped high bound, idx_b = clamped (low - 1), or 0
  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  idx_a;
    logic [POS_W-1:0]  idx_b;
    logic [DATA_W-1:0] delta;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_RESULT
  } bk_state_e;

endpackage

### hw/rtl/fenwick_front.sv
// ----------------------------------------------------------------------------
// Fenwick tree front end
// Accepts items, drops void adds, clamps query bounds into commands.
// ----------------------------------------------------------------------------
module fenwick_front import fenwick_pkg::*; #(
  parameter int unsigned SIZE = 1024
) (
  input  logic                     push,
  output logic                     full,
  input  logic                     op_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] delta_i,
  input  logic [POS_W-1:0]         range_low_i,
  input  logic [POS_W-1:0]         range_high_i,
  input  logic                     fifo_full_i,
  input  logic                     clearing_i,
  output logic                     enq_o,
  output cmd_t                     cmd_o
);

  localparam logic [POS_W-1:0] MaxPos =
    (SIZE > (1 << POS_W)) ? {POS_W{1'b1}} : POS_W'(SIZE - 1);
  localparam logic [POS_W:0] SizeLim =
    (SIZE > (1 << POS_W)) ? {1'b1, {POS_W{1'b0}}} : (POS_W + 1)'(SIZE);

  logic             pos_void;
  logic [POS_W-1:0] low_m1;

  always_comb begin
    full     = fifo_full_i | clearing_i;
    pos_void = (position_i == '0) || ({1'b0, position_i} >= SizeLim);
    low_m1   = (range_low_i == '0) ? '0 : range_low_i - POS_W'(1);

    cmd_o.op    = op_e'(op_i);
    cmd_o.delta = delta_i;
    if (op_e'(op_i) == OP_QUERY) begin
      cmd_o.idx_a = (range_high_i > MaxPos) ? MaxPos : range_high_i;
      cmd_o.idx_b = (low_m1 > MaxPos) ? MaxPos : low_m1;
    end else begin
      cmd_o.idx_a = position_i;
      cmd_o.idx_b = '0;
    end

    // a void add is taken and discarded
    enq_o = push && !full && !((op_e'(op_i) == OP_ADD) && pos_void);
  end

endmodule

### hw/rtl/fenwick_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Fenwick tree command queue
// Two-entry queue between front end and back end.
// ----------------------------------------------------------------------------
module fenwick_cmd_fifo import fenwick_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic empty_o,
  input  logic deq_i,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    full_o   = (cnt_q == 2'd2);
    empty_o  = (cnt_q == 2'd0);
    cmd_o    = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q ^ enq_i;
    rd_ptr_d = rd_ptr_q ^ deq_i;
    cnt_d    = cnt_q + {1'b0, enq_i} - {1'b0, deq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !enq_i || deq_i) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> !empty_o) else $error("command queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq_i && !deq_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("command queue count slip");
`endif

endmodule

### hw/rtl/fenwick_back.sv
// ----------------------------------------------------------------------------
// Fenwick tree back end
// Node store, clear sweep, tree walks and the result register.
// ----------------------------------------------------------------------------
module fenwick_back import fenwick_pkg::*; #(
  parameter int unsigned SIZE = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_empty_i,
  input  cmd_t                     cmd_i,
  output logic                     deq_o,
  output logic                     clearing_o,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] range_sum_o
);

  localparam int unsigned IW = $clog2(SIZE);
  localparam int unsigned AW = IW + 1;
  localparam logic [AW-1:0] SizeA = AW'(SIZE);
  localparam logic [IW-1:0] LastA = IW'(SIZE - 1);

  logic [DATA_W-1:0] mem [SIZE];
  logic [DATA_W-1:0] rd_q;

  bk_state_e         state_q, state_d;
  logic [IW-1:0]     clr_q, clr_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [POS_W-1:0]  lo_idx_q, lo_idx_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [DATA_W-1:0] upper_q, upper_d;
  op_e               op_q, op_d;
  logic              phase_q, phase_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_q, out_d;

  logic              we, re;
  logic [IW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     lowbit, nxt_up, nxt_dn;
  logic [DATA_W-1:0] sum;
  logic              fin;

  always_comb begin
    lowbit = idx_q & (~idx_q + AW'(1));
    nxt_up = idx_q + lowbit;
    nxt_dn = idx_q & (idx_q - AW'(1));

    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    lo_idx_d  = lo_idx_q;
    delta_d   = delta_q;
    acc_d     = acc_q;
    upper_d   = upper_q;
    op_d      = op_q;
    phase_d   = phase_q;
    out_vld_d = out_vld_q && !pop;
    out_d     = out_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_q[IW-1:0];
    raddr     = idx_q[IW-1:0];
    wdata     = rd_q + delta_q;
    deq_o     = 1'b0;
    sum       = acc_q;
    fin       = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + IW'(1);
        if (clr_q == LastA) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          deq_o    = 1'b1;
          op_d     = cmd_i.op;
          idx_d    = AW'(cmd_i.idx_a);
          lo_idx_d = cmd_i.idx_b;
          delta_d  = cmd_i.delta;
          acc_d    = '0;
          phase_d  = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (idx_q == '0) begin
          fin = 1'b1;
        end else begin
          re      = 1'b1;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (op_q == OP_ADD) begin
          we = 1'b1;
          if (nxt_up >= SizeA) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = nxt_up;
            raddr = nxt_up[IW-1:0];
            re    = 1'b1;
          end
        end else begin
          sum   = acc_q + rd_q;
          acc_d = sum;
          if (nxt_dn == '0) begin
            fin = 1'b1;
          end else begin
            idx_d = nxt_dn;
            raddr = nxt_dn[IW-1:0];
            re    = 1'b1;
          end
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || pop) begin
          out_vld_d = 1'b1;
          out_d     = acc_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // end of one prefix walk
    if (fin) begin
      if (!phase_q) begin
        upper_d = sum;
        acc_d   = '0;
        idx_d   = AW'(lo_idx_q);
        phase_d = 1'b1;
        state_d = ST_LOAD;
      end else begin
        acc_d   = upper_q - sum;
        state_d = ST_RESULT;
      end
    end
  end

  always_comb begin
    clearing_o  = (state_q == ST_CLEAR);
    empty       = !out_vld_q;
    range_sum_o = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      op_q      <= OP_ADD;
      phase_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      op_q      <= op_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    lo_idx_q <= lo_idx_d;
    delta_q  <= delta_d;
    acc_q    <= acc_d;
    upper_q  <= upper_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |-> idx_q < SizeA) else $error("walk index out of range");
  a_step_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP |-> $past(re)) else $error("step without node read");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_vld_q && !pop) |=> state_q == ST_RESULT)
    else $error("result register overwritten");
  a_deq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> state_q == ST_IDLE && !cmd_empty_i) else $error("bad dequeue");
`endif

endmodule

### hw/rtl/fenwick_tree_point_add_range_sum.sv
// ----------------------------------------------------------------------------
// Fenwick tree, point add and range sum
// Queue-style in and out channels around a binary indexed tree store.
// ----------------------------------------------------------------------------
// Input: an item transfers when push is high and full is low. op_i = 0 adds
// delta_i at position_i (position 0 or beyond SIZE-1 is discarded); op_i = 1
// asks for the sum over range_low_i .. range_high_i.
// Output: while empty is low, range_sum_o holds the oldest result; it
// transfers when pop is high. Adds give no result.
// A two-entry command queue splits the front end from the tree walker, so
// items are taken while the walker is busy or a result waits to be popped.
// Timing: one node of the store is visited per cycle through its single read
// port. An add holds the walker for one walk up the tree from its position,
// and a query for two walks down it, to the high bound and then to low - 1,
// before its difference is registered as the result.
// Reset: the store is swept to zero one node per cycle, with full held
// high; nothing is accepted until the sweep ends.
// A stalled pop holds the walker after its next query; the queue then fills
// and full rises.
// ----------------------------------------------------------------------------
module fenwick_tree_point_add_range_sum import fenwick_pkg::*; #(
  parameter int unsigned SIZE = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic                     op_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] delta_i,
  input  logic [POS_W-1:0]         range_low_i,
  input  logic [POS_W-1:0]         range_high_i,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [DATA_W-1:0] range_sum_o
);

  logic enq, deq, q_full, q_empty, clearing;
  cmd_t enq_cmd, head_cmd;

  fenwick_front #(.SIZE(SIZE)) u_front (
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .position_i   (position_i),
    .delta_i      (delta_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .fifo_full_i  (q_full),
    .clearing_i   (clearing),
    .enq_o        (enq),
    .cmd_o        (enq_cmd)
  );

  fenwick_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .cmd_i   (enq_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .deq_i   (deq),
    .cmd_o   (head_cmd)
  );

  fenwick_back #(.SIZE(SIZE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_i       (head_cmd),
    .deq_o       (deq),
    .clearing_o  (clearing),
    .empty       (empty),
    .pop         (pop),
    .range_sum_o (range_sum_o)
  );

endmodule
